/* rtl/kcd_pkg.sv */
package kcd_pkg;

  localparam int unsigned FLAG_W = 6;

  // Flag select codes; each one is also the bit position in the flag word.
  localparam logic [2:0] FLAG_PRESS    = 3'd0;
  localparam logic [2:0] FLAG_RELEASE  = 3'd1;
  localparam logic [2:0] FLAG_DOUBLE   = 3'd2;
  localparam logic [2:0] FLAG_TRIPLE   = 3'd3;
  localparam logic [2:0] FLAG_PRESSING = 3'd4;
  localparam logic [2:0] FLAG_LONG     = 3'd5;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_SCAN_DIVIDER = 2'd0;
  localparam logic [1:0] REG_HOLD_SCANS   = 2'd1;
  localparam logic [1:0] REG_GAP_SCANS    = 2'd2;

  localparam logic [15:0] SCAN_DIVIDER_RST = 16'd20;
  localparam logic [7:0]  HOLD_SCANS_RST   = 8'd5;
  localparam logic [7:0]  GAP_SCANS_RST    = 8'd5;

  localparam logic [7:0]  CNT8_MAX  = 8'hFF;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [1:0]  CLICK_MAX = 2'd3;

  typedef struct packed {
    logic       scan;
    logic       query;
    logic [2:0] flag_select;
    logic [7:0] hold_scans;
    logic [7:0] gap_scans;
  } lane_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [FLAG_W-1:0] flags;
  } lane_stat_t;

  typedef struct packed {
    logic              flag_hit;
    logic [FLAG_W-1:0] key_flags;
  } result_t;

endpackage

/* rtl/multi_key_click_detector.sv */
// Click and long-press detector for active-low key pins.
// Input channel (in_valid / in_stall) carries one beat per item: a tick
// (command 0) with the raw pin levels in key_levels, or a query (command 1)
// that reads flag flag_select of key key_index and clears it (PRESSING is
// live and never cleared). A scan of all keys runs on every scan_divider-th
// tick; every key has its own lane, so a scan handles all keys together.
// Output channel (out_valid / out_stall) returns one beat per item: flag_hit
// and the six flag bits of key key_index after the item took effect.
// Each result is registered in the output buffer (main entry, or skid entry
// while the output stalls); throughput is one item per cycle while in_stall is low.
// A two-entry output buffer keeps taking input while a result waits; in_stall
// rises only when both entries hold results the receiver has not taken.
// Registers (APB, byte address 4*i): scan_divider at 0, hold_scans at 4,
// gap_scans at 8. Write them only while the block is idle.
// Synchronous reset clears all key state, the prescaler and the output buffer
// and restores the register defaults (20, 5, 5).
module multi_key_click_detector
  import kcd_pkg::*;
#(
  parameter int unsigned KEYS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [3:0]  key_levels,
  input  logic [1:0]  key_index,
  input  logic [2:0]  flag_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        flag_hit,
  output logic [5:0]  key_flags
);

  logic [15:0] scan_divider;
  logic [7:0]  hold_scans;
  logic [7:0]  gap_scans;
  logic        cfg_write;
  logic [1:0]  reg_index;

  logic [15:0] prescale_count, prescale_count_next;
  logic [15:0] prescale_inc;
  logic        in_fire;
  logic        tick;
  logic        scan;
  logic        key_in_range;
  logic        query;
  logic        buf_full;

  lane_ctrl_t      ctrl;
  lane_stat_t      stat [KEYS];
  logic [KEYS-1:0] lane_sel;
  result_t         merged;
  result_t         out_data;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_divider <= SCAN_DIVIDER_RST;
      hold_scans   <= HOLD_SCANS_RST;
      gap_scans    <= GAP_SCANS_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_SCAN_DIVIDER: scan_divider <= pwdata[15:0];
        REG_HOLD_SCANS:   hold_scans   <= pwdata[7:0];
        REG_GAP_SCANS:    gap_scans    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SCAN_DIVIDER: prdata = {16'd0, scan_divider};
      REG_HOLD_SCANS:   prdata = {24'd0, hold_scans};
      REG_GAP_SCANS:    prdata = {24'd0, gap_scans};
      default:          prdata = '0;
    endcase
  end

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !in_stall;
  assign tick     = in_fire && (command == CMD_TICK);

  // prescaler: saturating count, scan when it reaches the divider
  assign prescale_inc = (prescale_count != CNT16_MAX) ? prescale_count + 16'd1
                                                      : prescale_count;
  assign scan = tick && (prescale_inc >= scan_divider);

  always_comb begin
    prescale_count_next = prescale_count;
    if (scan) begin
      prescale_count_next = '0;
    end else if (tick) begin
      prescale_count_next = prescale_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
    end else begin
      prescale_count <= prescale_count_next;
    end
  end

  assign key_in_range = 32'(key_index) < KEYS;
  assign query = in_fire && (command == CMD_QUERY) && key_in_range
                 && (flag_select <= FLAG_LONG);

  assign ctrl.scan        = scan;
  assign ctrl.query       = query;
  assign ctrl.flag_select = flag_select;
  assign ctrl.hold_scans  = hold_scans;
  assign ctrl.gap_scans   = gap_scans;

  for (genvar i = 0; i < KEYS; i++) begin : g_lane
    logic now;
    if (i < 4) begin : g_pin
      assign now         = !key_levels[i];
      assign lane_sel[i] = (key_index == 2'(i));
    end else begin : g_nopin
      assign now         = 1'b0;
      assign lane_sel[i] = 1'b0;
    end

    kcd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .now      (now),
      .lane_sel (lane_sel[i]),
      .stat     (stat[i])
    );
  end

  kcd_merge #(
    .KEYS (KEYS)
  ) u_merge (
    .stat     (stat),
    .lane_sel (lane_sel),
    .result   (merged)
  );

  kcd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_data   (merged),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign flag_hit  = out_data.flag_hit;
  assign key_flags = out_data.key_flags;

  a_no_hit_without_query: assert property (@(posedge clk) disable iff (rst)
    !query |-> !merged.flag_hit)
    else $error("flag hit reported without a query");

  a_scan_clears_prescaler: assert property (@(posedge clk) disable iff (rst)
    scan |=> prescale_count == '0)
    else $error("prescaler not cleared after scan");

  a_pressing_tracks_pin: assert property (@(posedge clk) disable iff (rst)
    scan && key_in_range |-> merged.key_flags[FLAG_PRESSING] == !key_levels[key_index])
    else $error("pressing flag differs from pin level after scan");

  a_full_implies_valid: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> out_valid)
    else $error("skid entry held while output stage empty");

endmodule

/* rtl/kcd_lane.sv */
module kcd_lane
  import kcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  logic       now,
  input  logic       lane_sel,
  output lane_stat_t stat
);

  logic [FLAG_W-1:0] flags, flags_next;
  logic              prev, prev_next;
  logic [7:0]        hold, hold_next;
  logic [7:0]        gap, gap_next;
  logic [1:0]        click, click_next;
  logic [FLAG_W-1:0] mask;
  logic              hit;

  assign mask = FLAG_W'(1) << ctrl.flag_select;

  always_comb begin
    flags_next = flags;
    prev_next  = prev;
    hold_next  = hold;
    gap_next   = gap;
    click_next = click;
    hit        = 1'b0;
    if (ctrl.scan) begin
      flags_next[FLAG_PRESSING] = now;
      if (!prev && now) begin
        flags_next[FLAG_PRESS] = 1'b1;
        gap_next = '0;
      end else if (prev && now) begin
        hold_next = (hold != CNT8_MAX) ? hold + 8'd1 : hold;
        if (hold_next >= ctrl.hold_scans) begin
          flags_next[FLAG_LONG] = 1'b1;
          hold_next = '0;
        end
      end else if (prev && !now) begin
        hold_next  = '0;
        click_next = (click != CLICK_MAX) ? click + 2'd1 : click;
        flags_next[FLAG_RELEASE] = 1'b1;
        gap_next   = 8'd1;
      end
      // close the click sequence once the key has stayed up long enough
      if (gap_next != '0 && !now) begin
        gap_next = (gap_next != CNT8_MAX) ? gap_next + 8'd1 : gap_next;
        if (gap_next >= ctrl.gap_scans) begin
          unique case (click_next)
            2'd3:    flags_next[FLAG_TRIPLE] = 1'b1;
            2'd2:    flags_next[FLAG_DOUBLE] = 1'b1;
            2'd1:    flags_next[FLAG_PRESS]  = 1'b1;
            default: ;
          endcase
          click_next = '0;
          gap_next   = '0;
        end
      end
      prev_next = now;
    end else if (ctrl.query && lane_sel) begin
      hit = |(flags & mask);
      if (hit && ctrl.flag_select != FLAG_PRESSING) begin
        flags_next = flags & ~mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      prev  <= 1'b0;
      hold  <= '0;
      gap   <= '0;
      click <= '0;
    end else begin
      flags <= flags_next;
      prev  <= prev_next;
      hold  <= hold_next;
      gap   <= gap_next;
      click <= click_next;
    end
  end

  assign stat.hit   = hit;
  assign stat.flags = flags_next;

endmodule

/* rtl/kcd_merge.sv */
module kcd_merge
  import kcd_pkg::*;
#(
  parameter int unsigned KEYS = 4
) (
  input  lane_stat_t      stat [KEYS],
  input  logic [KEYS-1:0] lane_sel,
  output result_t         result
);

  // lane_sel is one-hot or zero, so an OR of the gated lanes picks the key
  always_comb begin
    result = '0;
    for (int unsigned i = 0; i < KEYS; i++) begin
      if (lane_sel[i]) begin
        result.flag_hit  = result.flag_hit | stat[i].hit;
        result.key_flags = result.key_flags | stat[i].flags;
      end
    end
  end

endmodule

/* rtl/kcd_out_buf.sv */
module kcd_out_buf
  import kcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  result_t in_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid, main_valid_next;
  logic    skid_valid, skid_valid_next;
  result_t main_data, skid_data;
  logic    main_load, skid_load;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_load       = 1'b0;
    skid_load       = 1'b0;
    if (!main_valid || !out_stall) begin
      // main stage is free: refill from skid first, else from the new beat
      if (skid_valid) begin
        main_valid_next = 1'b1;
        skid_valid_next = 1'b0;
      end else begin
        main_valid_next = in_fire;
        main_load       = in_fire;
      end
    end else if (in_fire) begin
      skid_valid_next = 1'b1;
      skid_load       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (main_load) begin
      main_data <= in_data;
    end else if (skid_valid && (!main_valid || !out_stall)) begin
      main_data <= skid_data;
    end
    if (skid_load) begin
      skid_data <= in_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule
